// ----- rtl/mlr_pkg.sv -----
package mlr_pkg;

	// Action codes of an input item.
	typedef enum logic [1:0] {
		ACT_LINE = 2'd0,
		ACT_OUTLINE = 2'd1,
		ACT_FILL = 2'd2,
		ACT_READ = 2'd3
	} action_t;

	// Bit position of the first pixel within a byte (most significant first).
	localparam int unsigned BIT_TOP = 7;
	localparam int unsigned BYTE_BITS = 8;

	// Coordinate widths, fixed by the item fields.
	localparam int unsigned XW = 8;
	localparam int unsigned YW = 6;

	// One line segment handed from the front part to the back part.
	typedef struct packed {
		logic [XW-1:0] xa;
		logic [YW-1:0] ya;
		logic [XW-1:0] xb;
		logic [YW-1:0] yb;
		logic ink;
		logic last;
	} seg_t;

	// What the back part reports to the front part.
	typedef struct packed {
		logic done;
		logic [7:0] data;
		logic is_read;
	} back_res_t;

endpackage

// ----- rtl/mlr_ram.sv -----
module mlr_ram #(
	parameter int unsigned DW = 8,
	parameter int unsigned DEPTH = 860
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [DW-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/mlr_front.sv -----
module mlr_front (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [1:0] action,
	input logic [7:0] x_start,
	input logic [5:0] y_start,
	input logic [7:0] x_end,
	input logic [5:0] y_end,
	input logic ink,
	input logic [9:0] byte_index,
	// Segment queue push side.
	output logic seg_push,
	output mlr_pkg::seg_t seg_data,
	input logic seg_full,
	// Read request to the back part.
	output logic rd_req,
	output logic [9:0] rd_addr,
	input mlr_pkg::back_res_t back_res,
	output logic strobe,
	output logic [7:0] read_data,
	output logic is_read
);

	typedef enum logic [2:0] {
		F_IDLE, F_LINE, F_EDGE, F_ROW, F_READ, F_WAIT
	} fstate_t;

	fstate_t state_q;
	logic [7:0] x1_q, x2_q;
	logic [5:0] y1_q, y2_q;
	logic ink_q;
	logic [1:0] edge_q;
	logic [5:0] row_q;
	logic [9:0] addr_q;
	logic accept;
	logic degen;
	mlr_pkg::seg_t seg_c;
	logic emit;

	assign busy = (state_q != F_IDLE);
	assign accept = start && !busy;
	assign degen = (x_start == x_end) || (y_start == y_end);

	// Segment chosen by the current line, edge or row.
	always_comb begin
		seg_c = '0;
		seg_c.ink = ink_q;
		emit = 1'b0;
		case (state_q)
			F_LINE: begin
				emit = 1'b1;
				seg_c.last = 1'b1;
				seg_c.xa = x1_q; seg_c.ya = y1_q;
				seg_c.xb = x2_q; seg_c.yb = y2_q;
			end
			F_EDGE: begin
				emit = 1'b1;
				seg_c.last = (edge_q == 2'd3);
				case (edge_q)
					2'd0: begin
						seg_c.xa = x1_q; seg_c.ya = y1_q;
						seg_c.xb = x2_q; seg_c.yb = y1_q;
					end
					2'd1: begin
						seg_c.xa = x1_q; seg_c.ya = y1_q;
						seg_c.xb = x1_q; seg_c.yb = y2_q;
					end
					2'd2: begin
						seg_c.xa = x1_q; seg_c.ya = y2_q;
						seg_c.xb = x2_q; seg_c.yb = y2_q;
					end
					default: begin
						seg_c.xa = x2_q; seg_c.ya = y1_q;
						seg_c.xb = x2_q; seg_c.yb = y2_q;
					end
				endcase
			end
			F_ROW: begin
				emit = 1'b1;
				seg_c.last = (row_q == y2_q);
				seg_c.xa = x1_q; seg_c.ya = row_q;
				seg_c.xb = x2_q; seg_c.yb = row_q;
			end
			default: ;
		endcase
	end

	assign seg_push = emit && !seg_full;
	assign seg_data = seg_c;
	assign rd_req = (state_q == F_READ);
	assign rd_addr = addr_q;

	// Command decoder and segment sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			strobe <= 1'b0;
			read_data <= '0;
			is_read <= 1'b0;
			edge_q <= '0;
			row_q <= '0;
		end else begin
			strobe <= 1'b0;
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						x1_q <= x_start; y1_q <= y_start;
						x2_q <= x_end; y2_q <= y_end;
						ink_q <= ink; addr_q <= byte_index;
						row_q <= y_start;
						edge_q <= '0;
						unique case (mlr_pkg::action_t'(action))
							mlr_pkg::ACT_READ: state_q <= F_READ;
							// A line is one segment, the last one.
							mlr_pkg::ACT_LINE: state_q <= F_LINE;
							mlr_pkg::ACT_OUTLINE: begin
								if (degen) begin
									strobe <= 1'b1;
									read_data <= '0;
									is_read <= 1'b0;
								end else begin
									state_q <= F_EDGE;
								end
							end
							default: begin
								if (degen || (y_start > y_end)) begin
									strobe <= 1'b1;
									read_data <= '0;
									is_read <= 1'b0;
								end else begin
									state_q <= F_ROW;
								end
							end
						endcase
					end
				end
				F_LINE: begin
					if (!seg_full) begin
						state_q <= F_WAIT;
					end
				end
				F_EDGE: begin
					if (!seg_full) begin
						if (edge_q == 2'd3) begin
							state_q <= F_WAIT;
						end
						edge_q <= edge_q + 2'd1;
					end
				end
				F_ROW: begin
					if (!seg_full) begin
						if (row_q == y2_q) begin
							state_q <= F_WAIT;
						end
						row_q <= row_q + 6'd1;
					end
				end
				F_READ: state_q <= F_WAIT;
				F_WAIT: begin
					if (back_res.done) begin
						strobe <= 1'b1;
						read_data <= back_res.data;
						is_read <= back_res.is_read;
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// A result never appears while an outline is still being split.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == F_EDGE) |=> !strobe)
		else $error("result during outline split");
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy || strobe)
		else $error("accepted item neither worked nor answered");
	assert property (@(posedge clk) disable iff (!arst_n)
		seg_push |-> busy)
		else $error("segment pushed while idle");

endmodule

// ----- rtl/mlr_back.sv -----
module mlr_back #(
	parameter int unsigned WIDTH = 160,
	parameter int unsigned HEIGHT = 43
) (
	input logic clk,
	input logic arst_n,
	input logic seg_valid,
	input mlr_pkg::seg_t seg_data,
	output logic seg_pop,
	input logic rd_req,
	input logic [9:0] rd_addr,
	output mlr_pkg::back_res_t back_res
);

	localparam int unsigned BYTES = (WIDTH * HEIGHT + mlr_pkg::BIT_TOP) / mlr_pkg::BYTE_BITS;
	localparam int unsigned AW = $clog2(BYTES);
	localparam int unsigned PW = $clog2(WIDTH * HEIGHT);
	localparam int unsigned EW = 11;

	typedef enum logic [2:0] {
		B_CLEAR, B_IDLE, B_PLOT, B_RMW, B_STEP, B_RDWAIT, B_RDOUT
	} bstate_t;

	bstate_t state_q;
	logic [AW-1:0] clr_q;
	logic signed [9:0] cx_q, cy_q, xb_q, yb_q;
	logic signed [EW-1:0] err_q, ax_q, ay_q;
	logic sx_q, sy_q, xmaj_q, ink_q, last_q;
	logic [AW-1:0] byte_q;
	logic [7:0] mask_q;
	logic [AW-1:0] raddr;
	logic [7:0] rdata;
	logic we;
	logic [AW-1:0] waddr;
	logic [7:0] wdata;
	logic rd_oor_q;
	logic rd_pend_q;
	logic inpanel;
	logic [PW-1:0] pos;
	logic signed [9:0] dx, dy;
	logic signed [9:0] nx, ny;
	logic signed [EW-1:0] nerr;
	logic walk_done;

	mlr_ram #(.DW(8), .DEPTH(BYTES)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	// Pixel address of the cursor.
	assign inpanel = (cx_q >= 0) && (int'(cx_q) < int'(WIDTH))
		&& (cy_q >= 0) && (int'(cy_q) < int'(HEIGHT));
	assign pos = PW'(32'(unsigned'(cy_q)) * WIDTH + 32'(unsigned'(cx_q)));

	// New segment deltas (0-based).
	assign dx = $signed({2'b0, seg_data.xb}) - $signed({2'b0, seg_data.xa});
	assign dy = $signed({4'b0, seg_data.yb}) - $signed({4'b0, seg_data.ya});

	// One Bresenham step.
	always_comb begin
		nx = cx_q; ny = cy_q; nerr = err_q;
		if (xmaj_q) begin
			if (err_q >= 0) begin
				ny = sy_q ? cy_q - 10'sd1 : cy_q + 10'sd1;
				nerr = nerr - ax_q;
			end
			nx = sx_q ? cx_q - 10'sd1 : cx_q + 10'sd1;
			nerr = nerr + ay_q;
		end else begin
			if (err_q >= 0) begin
				nx = sx_q ? cx_q - 10'sd1 : cx_q + 10'sd1;
				nerr = nerr - ay_q;
			end
			ny = sy_q ? cy_q - 10'sd1 : cy_q + 10'sd1;
			nerr = nerr + ax_q;
		end
	end
	assign walk_done = xmaj_q ? (cx_q == xb_q) : (cy_q == yb_q);

	// The buffer read is issued in the cycle before its data is used.
	assign seg_pop = (state_q == B_IDLE) && seg_valid;
	assign raddr = ((state_q == B_IDLE) || (state_q == B_RDWAIT)) ? AW'(rd_addr) :
		((state_q == B_PLOT) ? AW'(pos >> 3) : byte_q);
	assign we = (state_q == B_CLEAR) || (state_q == B_RMW);
	assign waddr = (state_q == B_CLEAR) ? clr_q : byte_q;
	assign wdata = (state_q == B_CLEAR) ? 8'd0 :
		(ink_q ? (rdata | mask_q) : (rdata & ~mask_q));

	// Walker: clear pass, then segments as read-modify-write per pixel, and byte reads.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_CLEAR;
			clr_q <= '0;
			back_res <= '0;
			rd_pend_q <= 1'b0;
		end else begin
			back_res.done <= 1'b0;
			// Hold a read request that arrives while the walker is occupied.
			if (rd_req && !((state_q == B_IDLE) && !seg_valid)) begin
				rd_pend_q <= 1'b1;
			end
			unique case (state_q)
				B_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(BYTES - 1)) begin
						state_q <= B_IDLE;
					end
				end
				B_IDLE: begin
					if (seg_valid) begin
						cx_q <= $signed({2'b0, seg_data.xa}) - 10'sd1;
						cy_q <= $signed({4'b0, seg_data.ya}) - 10'sd1;
						xb_q <= $signed({2'b0, seg_data.xb}) - 10'sd1;
						yb_q <= $signed({4'b0, seg_data.yb}) - 10'sd1;
						sx_q <= dx[9];
						sy_q <= dy[9];
						ax_q <= EW'(dx[9] ? -dx : dx) <<< 1;
						ay_q <= EW'(dy[9] ? -dy : dy) <<< 1;
						xmaj_q <= (dx[9] ? -dx : dx) > (dy[9] ? -dy : dy);
						if ((dx[9] ? -dx : dx) > (dy[9] ? -dy : dy)) begin
							err_q <= (EW'(dy[9] ? -dy : dy) <<< 1) - EW'(dx[9] ? -dx : dx);
						end else begin
							err_q <= (EW'(dx[9] ? -dx : dx) <<< 1) - EW'(dy[9] ? -dy : dy);
						end
						ink_q <= seg_data.ink;
						last_q <= seg_data.last;
						state_q <= B_PLOT;
					end else if (rd_req || rd_pend_q) begin
						rd_oor_q <= (32'(rd_addr) >= BYTES);
						rd_pend_q <= 1'b0;
						state_q <= B_RDWAIT;
					end
				end
				B_RDWAIT: state_q <= B_RDOUT;
				B_RDOUT: begin
					back_res.done <= 1'b1;
					back_res.is_read <= 1'b1;
					back_res.data <= rd_oor_q ? 8'd0 : rdata;
					state_q <= B_IDLE;
				end
				B_PLOT: begin
					// Issue the byte read for the cursor pixel, or skip it.
					byte_q <= AW'(pos >> 3);
					mask_q <= 8'h80 >> pos[2:0];
					state_q <= inpanel ? B_RMW : B_STEP;
				end
				B_RMW: state_q <= B_STEP;
				B_STEP: begin
					if (walk_done) begin
						state_q <= B_IDLE;
						if (last_q) begin
							back_res.done <= 1'b1;
							back_res.is_read <= 1'b0;
							back_res.data <= '0;
						end
					end else begin
						cx_q <= nx; cy_q <= ny; err_q <= nerr;
						state_q <= B_PLOT;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_RMW) |-> $past(state_q == B_PLOT))
		else $error("write without pixel fetch");
	assert property (@(posedge clk) disable iff (!arst_n)
		back_res.done |=> !back_res.done)
		else $error("double completion");
	assert property (@(posedge clk) disable iff (!arst_n)
		seg_pop |=> state_q == B_PLOT)
		else $error("segment lost");

endmodule

// ----- rtl/mono_line_rect_raster_engine.sv -----
// A draw does a read-modify-write of the frame buffer per pixel on the longer axis
// of each segment, and skips the write for a pixel off the panel. A rectangle with
// equal x or y coordinates, or a fill with y_start greater than y_end, is answered
// with nothing drawn. One item is worked at a time.
// Reset clears control at once, then a clearing pass of one byte per cycle zeroes
// the buffer; drawing and reads wait until it ends.
// Results are a one-cycle strobe; the receiver cannot stall.
module mono_line_rect_raster_engine #(
	parameter int unsigned WIDTH = 160,
	parameter int unsigned HEIGHT = 43
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [1:0] action,
	input logic [7:0] x_start,
	input logic [5:0] y_start,
	input logic [7:0] x_end,
	input logic [5:0] y_end,
	input logic ink,
	input logic [9:0] byte_index,
	output logic strobe,
	output logic [7:0] read_data,
	output logic is_read
);

	mlr_pkg::seg_t push_data, q_data_q;
	logic push, full, pop, q_valid_q;
	logic rd_req;
	logic [9:0] rd_addr;
	mlr_pkg::back_res_t back_res;

	// One-entry queue between the command front and the pixel walker.
	assign full = q_valid_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_valid_q <= 1'b0;
		end else begin
			if (push) begin
				q_valid_q <= 1'b1;
			end else if (pop) begin
				q_valid_q <= 1'b0;
			end
		end
	end
	always_ff @(posedge clk) begin
		if (push) begin
			q_data_q <= push_data;
		end
	end

	mlr_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .x_start(x_start), .y_start(y_start),
		.x_end(x_end), .y_end(y_end), .ink(ink), .byte_index(byte_index),
		.seg_push(push), .seg_data(push_data), .seg_full(full),
		.rd_req(rd_req), .rd_addr(rd_addr), .back_res(back_res),
		.strobe(strobe), .read_data(read_data), .is_read(is_read)
	);

	mlr_back #(.WIDTH(WIDTH), .HEIGHT(HEIGHT)) u_back (
		.clk(clk), .arst_n(arst_n), .seg_valid(q_valid_q), .seg_data(q_data_q),
		.seg_pop(pop), .rd_req(rd_req), .rd_addr(rd_addr), .back_res(back_res)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_valid_q)
		else $error("queue overrun");
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid_q)
		else $error("queue underrun");
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(start || busy))
		else $error("result with no item in progress");

endmodule
